// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the occupancy controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olfc same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OLFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olfc next-cycle check failed");

`endif

// ===== src/olfc_pkg.sv =====
// Types, constants and phase action functions of the occupancy controller.
package olfc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_FAN_OFF   = 3'd1,
        PH_OCCUPIED  = 3'd2,
        PH_CLOSED    = 3'd3,
        PH_CHECK     = 3'd4,
        PH_LEAVING   = 3'd5,
        PH_ANNOUNCE  = 3'd6,
        PH_ALARM     = 3'd7
    } t_phase;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FORCE  = 1'b1;

    localparam logic [1:0] CFG_DETECT_SAMPLES = 2'd0;
    localparam logic [1:0] CFG_IDLE_FAN_HOURS = 2'd1;
    localparam logic [1:0] CFG_MANUAL_FAN     = 2'd2;
    localparam logic [1:0] CFG_MANUAL_MUSIC   = 2'd3;

    localparam int IDLE_LIMIT_BITS = 28;
    localparam int HOUR_SECONDS    = 60 * 60;
    localparam int ANNOUNCE_WAIT   = 3 * 60;
    localparam int ALARM_WAIT      = 20;
    localparam int CHECK_WAIT      = 7;
    localparam int LEAVING_WAIT    = 5;
    localparam int CLOSED_WAIT     = 3;

    localparam logic [9:0]  DETECT_RESET = 10'd2;
    localparam logic [IDLE_LIMIT_BITS-1:0] IDLE_LIMIT_RESET =
        IDLE_LIMIT_BITS'(80 * HOUR_SECONDS);
    localparam logic [15:0] PIR_MAX = 16'hFFFF;

    typedef struct packed {
        logic       light;
        logic       fan;
        logic       music;
        logic [1:0] rep_n;
        logic       rep_first;
        logic       rep_second;
    } t_act_state;

    function automatic t_act_state f_report(t_act_state s, logic v);
        t_act_state r;
        r = s;
        case (s.rep_n)
            2'd0: begin
                r.rep_first = v;
                r.rep_n     = 2'd1;
            end
            2'd1: begin
                r.rep_second = v;
                r.rep_n      = 2'd2;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_act_state f_migrate(t_act_state s, t_phase p, logic manual_music);
        t_act_state r;
        r = s;
        case (p)
            PH_IDLE: begin
                r.light = 1'b0;
                r.fan   = 1'b1;
                r.music = 1'b0;
                r = f_report(r, 1'b0);
            end
            PH_FAN_OFF: begin
                r.light = 1'b0;
                r.fan   = 1'b0;
            end
            PH_OCCUPIED: begin
                r.light = 1'b1;
                r.fan   = 1'b0;
                if (!s.music) begin
                    r.music = 1'b1;
                    if (!manual_music) begin
                        r = f_report(r, 1'b1);
                    end
                end
            end
            PH_LEAVING: begin
                r.light = 1'b0;
            end
            PH_ALARM: begin
                r.fan   = 1'b1;
                r.music = 1'b0;
                r = f_report(r, 1'b0);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

endpackage

// ===== src/occupancy_light_fan_controller.sv =====
// A word accepted goes into the input register; its result goes into the result register,
// which drives the outputs. Throughput: one word per cycle unless the output stalls; the
// phase update is combinational between the two registers, so back-to-back words keep their
// order. A stalled result holds the compute stage; an empty input register still takes one.
// Reset (synchronous, active low) puts the phase in idle, clears the phase start times,
// sets the fan on and restores the register defaults; no clearing pass is needed.
`include "assert_macros.svh"

module occupancy_light_fan_controller #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic        i_pir_raw,
    input  logic        i_reed_raw,
    input  logic [31:0] i_now_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_phase_code,
    output logic        o_light_on,
    output logic        o_fan_on,
    output logic        o_music_on,
    output logic        o_led_on,
    output logic        o_person_present,
    output logic        o_door_level,
    output logic        o_door_changed,
    output logic [1:0]  o_report_count,
    output logic        o_report_first,
    output logic        o_report_second
);
    import olfc_pkg::*;

    localparam int CMP_BITS = (TIME_BITS > IDLE_LIMIT_BITS) ? TIME_BITS : IDLE_LIMIT_BITS;

    logic [9:0]                 r_detect;
    logic [IDLE_LIMIT_BITS-1:0] r_idle_limit;
    logic                       r_manual_fan;
    logic                       r_manual_music;

    logic                 r_in_valid;
    logic                 r_cmd;
    logic                 r_pir;
    logic                 r_reed;
    logic [TIME_BITS-1:0] r_now;

    t_phase               r_phase, n_phase;
    logic [TIME_BITS-1:0] r_phase_start [8];
    logic [TIME_BITS-1:0] n_phase_start [8];
    logic                 r_door_prev, n_door_prev;
    logic [15:0]          r_pir_count, n_pir_count;
    logic                 r_light, r_fan, r_music;
    logic                 r_led, n_led;

    logic       r_out_valid;
    logic [2:0] r_out_phase;
    logic       r_out_light, r_out_fan, r_out_music, r_out_led;
    logic       r_out_present, r_out_door_level, r_out_door_changed;
    logic [1:0] r_out_rep_n;
    logic       r_out_rep_first, r_out_rep_second;

    logic                 w_advance;
    logic                 w_fire;
    logic                 w_present;
    logic                 w_door_level;
    logic                 w_door_changed;
    logic                 w_open_edge;
    logic                 w_close_edge;
    logic [TIME_BITS-1:0] w_since;
    logic [CMP_BITS-1:0]  w_limit;
    logic                 w_elapsed;
    logic                 w_a1_valid, w_a2_valid, w_stamp_occupied;
    t_phase               w_a1, w_a2;
    t_act_state           w_s0, w_s1, w_s2;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect       <= DETECT_RESET;
            r_idle_limit   <= IDLE_LIMIT_RESET;
            r_manual_fan   <= 1'b0;
            r_manual_music <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DETECT_SAMPLES: r_detect <= i_cfg_data[9:0];
                CFG_IDLE_FAN_HOURS: r_idle_limit <= IDLE_LIMIT_BITS'(i_cfg_data)
                                                  * IDLE_LIMIT_BITS'(HOUR_SECONDS);
                CFG_MANUAL_FAN:     r_manual_fan <= i_cfg_data[0];
                CFG_MANUAL_MUSIC:   r_manual_music <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd  <= i_command;
            r_pir  <= i_pir_raw;
            r_reed <= i_reed_raw;
            r_now  <= TIME_BITS'(i_now_seconds);
        end
    end

    assign w_since = r_now - r_phase_start[r_phase];

    always_comb begin
        case (r_phase)
            PH_IDLE:     w_limit = CMP_BITS'(r_idle_limit);
            PH_OCCUPIED: w_limit = CMP_BITS'(ANNOUNCE_WAIT);
            PH_CLOSED:   w_limit = CMP_BITS'(CLOSED_WAIT);
            PH_CHECK:    w_limit = CMP_BITS'(CHECK_WAIT);
            PH_LEAVING:  w_limit = CMP_BITS'(LEAVING_WAIT);
            PH_ANNOUNCE: w_limit = CMP_BITS'(ALARM_WAIT);
            default:     w_limit = '0;
        endcase
    end

    assign w_elapsed = CMP_BITS'(w_since) >= w_limit;

    always_comb begin
        n_door_prev      = r_door_prev;
        n_pir_count      = r_pir_count;
        n_led            = r_led;
        w_present        = 1'b0;
        w_door_level     = r_door_prev;
        w_door_changed   = 1'b0;
        w_a1_valid       = 1'b0;
        w_a1             = PH_IDLE;
        w_a2_valid       = 1'b0;
        w_a2             = PH_IDLE;
        w_stamp_occupied = 1'b0;

        if (r_cmd == CMD_FORCE) begin
            w_a1_valid = 1'b1;
            w_a1       = PH_IDLE;
        end else begin
            w_door_level   = r_reed;
            w_door_changed = r_reed != r_door_prev;
            n_door_prev    = r_reed;
            if (r_pir) begin
                if (r_pir_count == 16'(r_detect)) begin
                    n_led = 1'b1;
                end
                w_present = r_pir_count >= 16'(r_detect);
                if (r_pir_count != PIR_MAX) begin
                    n_pir_count = r_pir_count + 16'd1;
                end
            end else begin
                n_led       = 1'b0;
                n_pir_count = '0;
            end
        end

        w_open_edge  = w_door_changed && w_door_level;
        w_close_edge = w_door_changed && !w_door_level;

        if (r_cmd == CMD_SAMPLE) begin
            case (r_phase)
                PH_IDLE: begin
                    w_a1_valid = w_open_edge;
                    w_a1       = PH_OCCUPIED;
                    w_a2_valid = w_present || w_elapsed;
                    w_a2       = w_present ? PH_OCCUPIED : PH_FAN_OFF;
                end
                PH_FAN_OFF: begin
                    w_a1_valid = w_open_edge;
                    w_a1       = PH_OCCUPIED;
                    w_a2_valid = w_present;
                    w_a2       = PH_OCCUPIED;
                end
                PH_OCCUPIED: begin
                    w_a1_valid       = w_close_edge;
                    w_a1             = PH_CLOSED;
                    w_stamp_occupied = w_present;
                    w_a2_valid       = !w_present && w_elapsed;
                    w_a2             = PH_ANNOUNCE;
                end
                PH_CLOSED: begin
                    w_a1_valid = w_open_edge;
                    w_a1       = PH_OCCUPIED;
                    w_a2_valid = !w_present && w_elapsed;
                    w_a2       = PH_CHECK;
                end
                PH_CHECK: begin
                    w_a1_valid = w_open_edge;
                    w_a1       = PH_OCCUPIED;
                    w_a2_valid = w_present || w_elapsed;
                    w_a2       = w_present ? PH_OCCUPIED : PH_LEAVING;
                end
                PH_LEAVING: begin
                    w_a1_valid = w_open_edge;
                    w_a1       = PH_OCCUPIED;
                    w_a2_valid = w_present || w_elapsed;
                    w_a2       = w_present ? PH_OCCUPIED : PH_IDLE;
                end
                PH_ANNOUNCE: begin
                    w_a1_valid = w_door_changed;
                    w_a1       = w_open_edge ? PH_OCCUPIED : PH_CLOSED;
                    w_a2_valid = w_present || w_elapsed;
                    w_a2       = w_present ? PH_OCCUPIED : PH_ALARM;
                end
                default: begin
                    w_a1_valid = w_door_changed;
                    w_a1       = w_open_edge ? PH_OCCUPIED : PH_CLOSED;
                end
            endcase
        end

        w_s0 = '{light: r_light, fan: r_fan, music: r_music,
                 rep_n: 2'd0, rep_first: 1'b0, rep_second: 1'b0};
        w_s1 = w_a1_valid ? f_migrate(w_s0, w_a1, r_manual_music) : w_s0;
        w_s2 = w_a2_valid ? f_migrate(w_s1, w_a2, r_manual_music) : w_s1;

        n_phase = w_a2_valid ? w_a2 : (w_a1_valid ? w_a1 : r_phase);

        for (int i = 0; i < 8; i++) begin
            n_phase_start[i] = r_phase_start[i];
            if ((w_a1_valid && w_a1 == t_phase'(i)) || (w_a2_valid && w_a2 == t_phase'(i))
                    || (w_stamp_occupied && PH_OCCUPIED == t_phase'(i))) begin
                n_phase_start[i] = r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_door_prev <= 1'b0;
            r_pir_count <= '0;
            r_light     <= 1'b0;
            r_fan       <= 1'b1;
            r_music     <= 1'b0;
            r_led       <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_phase_start[i] <= '0;
            end
        end else if (w_fire) begin
            r_phase       <= n_phase;
            r_door_prev   <= n_door_prev;
            r_pir_count   <= n_pir_count;
            r_light       <= w_s2.light;
            r_fan         <= w_s2.fan;
            r_music       <= w_s2.music;
            r_led         <= n_led;
            r_phase_start <= n_phase_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_phase        <= n_phase;
            r_out_light        <= w_s2.light;
            r_out_fan          <= r_manual_fan | w_s2.fan;
            r_out_music        <= w_s2.music;
            r_out_led          <= n_led;
            r_out_present      <= w_present;
            r_out_door_level   <= w_door_level;
            r_out_door_changed <= w_door_changed;
            r_out_rep_n        <= w_s2.rep_n;
            r_out_rep_first    <= w_s2.rep_first;
            r_out_rep_second   <= w_s2.rep_second;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_phase_code     = r_out_phase;
    assign o_light_on       = r_out_light;
    assign o_fan_on         = r_out_fan;
    assign o_music_on       = r_out_music;
    assign o_led_on         = r_out_led;
    assign o_person_present = r_out_present;
    assign o_door_level     = r_out_door_level;
    assign o_door_changed   = r_out_door_changed;
    assign o_report_count   = r_out_rep_n;
    assign o_report_first   = r_out_rep_first;
    assign o_report_second  = r_out_rep_second;

    `OLFC_ASSERT_NEXT(a_held_word_kept, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid)
    `OLFC_ASSERT_IMP(a_idle_fan_on, i_clk, i_rst_n, r_phase == PH_IDLE, r_fan && !r_music)
    `OLFC_ASSERT_IMP(a_fan_off_phase, i_clk, i_rst_n, r_phase == PH_FAN_OFF, !r_fan && !r_light)
    `OLFC_ASSERT_IMP(a_occupied_outputs, i_clk, i_rst_n, r_phase == PH_OCCUPIED,
        r_light && r_music && !r_fan)

endmodule

// ===== sim/occupancy_light_fan_controller_tb.sv =====
// Self-checking testbench for the occupancy light and fan controller.
`timescale 1ns / 1ps

module occupancy_light_fan_controller_tb;
    import olfc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEMS_PER_SET = 118;
    localparam int SETTINGS_RUN  = 8;

    typedef struct packed {
        logic        command;
        logic        pir;
        logic        reed;
        logic [31:0] now_s;
    } t_sample;

    typedef struct packed {
        t_phase     phase;
        logic       light;
        logic       fan;
        logic       music;
        logic       led;
        logic       present;
        logic       door_level;
        logic       door_changed;
        logic [1:0] rep_n;
        logic       rep_first;
        logic       rep_second;
    } t_room_result;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_reg_write;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_command = 1'b0;
    logic        in_pir = 1'b0;
    logic        in_reed = 1'b0;
    logic [31:0] in_now = '0;
    logic        out_ready = 1'b0;

    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_phase_code;
    logic        o_light_on;
    logic        o_fan_on;
    logic        o_music_on;
    logic        o_led_on;
    logic        o_person_present;
    logic        o_door_level;
    logic        o_door_changed;
    logic [1:0]  o_report_count;
    logic        o_report_first;
    logic        o_report_second;

    t_sample      samples_q[$];
    t_reg_write   reg_writes_q[$];
    t_room_result room_results_due[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_arm = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    logic [7:0]  phases_seen = '0;
    logic [1:0]  most_reports = '0;

    // Predicted room state and register copy.
    t_phase      ph = PH_IDLE;
    logic [31:0] ph_start [8] = '{default: '0};
    logic        door_last = 1'b0;
    logic [15:0] pir_run = '0;
    logic        light_s = 1'b0;
    logic        fan_s = 1'b1;
    logic        music_s = 1'b0;
    logic        led_s = 1'b0;
    logic [9:0]  cfg_detect = DETECT_RESET;
    logic [15:0] cfg_idle_hours = 16'd80;
    logic        cfg_man_fan = 1'b0;
    logic        cfg_man_music = 1'b0;
    logic [31:0] t_now = '0;
    logic [1:0]  rep_n = '0;
    logic        rep_first = 1'b0;
    logic        rep_second = 1'b0;

    // Stimulus generator state.
    logic [31:0] gen_now = 32'd1000;
    logic        gen_pir = 1'b0;
    logic        gen_reed = 1'b0;

    occupancy_light_fan_controller dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (in_command),
        .i_pir_raw        (in_pir),
        .i_reed_raw       (in_reed),
        .i_now_seconds    (in_now),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_phase_code     (o_phase_code),
        .o_light_on       (o_light_on),
        .o_fan_on         (o_fan_on),
        .o_music_on       (o_music_on),
        .o_led_on         (o_led_on),
        .o_person_present (o_person_present),
        .o_door_level     (o_door_level),
        .o_door_changed   (o_door_changed),
        .o_report_count   (o_report_count),
        .o_report_first   (o_report_first),
        .o_report_second  (o_report_second)
    );

    always #6 clk = ~clk;

    function automatic void push_report(logic v);
        if (rep_n == 2'd0) begin
            rep_first = v;
            rep_n = 2'd1;
        end else if (rep_n == 2'd1) begin
            rep_second = v;
            rep_n = 2'd2;
        end
    endfunction

    function automatic void mark(t_phase p);
        ph_start[p] = t_now;
        ph = p;
    endfunction

    function automatic logic timed_out(t_phase p, longint unsigned span);
        logic [31:0] d;
        d = t_now - ph_start[p];
        return 64'(d) >= span;
    endfunction

    function automatic void to_idle();
        light_s = 1'b0;
        fan_s = 1'b1;
        music_s = 1'b0;
        push_report(1'b0);
        mark(PH_IDLE);
    endfunction

    function automatic void to_occupied();
        light_s = 1'b1;
        fan_s = 1'b0;
        if (!music_s) begin
            music_s = 1'b1;
            if (!cfg_man_music) begin
                push_report(1'b1);
            end
        end
        mark(PH_OCCUPIED);
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [15:0] data);
        case (idx)
            CFG_DETECT_SAMPLES: cfg_detect = data[9:0];
            CFG_IDLE_FAN_HOURS: cfg_idle_hours = data;
            CFG_MANUAL_FAN:     cfg_man_fan = data[0];
            default:            cfg_man_music = data[0];
        endcase
    endfunction

    // Advances the predicted room state by one word and returns the expected result.
    function automatic t_room_result advance_room(t_sample s);
        t_room_result r;
        logic present;
        logic changed;
        logic open_e;
        logic close_e;
        present = 1'b0;
        changed = 1'b0;
        r = '0;
        t_now = s.now_s;
        rep_n = 2'd0;
        rep_first = 1'b0;
        rep_second = 1'b0;
        r.door_level = door_last;
        if (s.command == CMD_FORCE) begin
            to_idle();
        end else begin
            changed = (s.reed != door_last);
            r.door_level = s.reed;
            door_last = s.reed;
            if (s.pir) begin
                if (pir_run == 16'(cfg_detect)) led_s = 1'b1;
                if (pir_run >= 16'(cfg_detect)) present = 1'b1;
                if (pir_run != PIR_MAX) pir_run = pir_run + 16'd1;
            end else begin
                led_s = 1'b0;
                pir_run = '0;
            end
            open_e = changed && s.reed;
            close_e = changed && !s.reed;
            case (ph)
                PH_IDLE: begin
                    if (open_e) to_occupied();
                    if (present) begin
                        to_occupied();
                    end else if (timed_out(PH_IDLE,
                                           64'(cfg_idle_hours) * 64'(HOUR_SECONDS))) begin
                        light_s = 1'b0;
                        fan_s = 1'b0;
                        mark(PH_FAN_OFF);
                    end
                end
                PH_FAN_OFF: begin
                    if (open_e) to_occupied();
                    if (present) to_occupied();
                end
                PH_OCCUPIED: begin
                    if (close_e) mark(PH_CLOSED);
                    if (present) begin
                        ph_start[PH_OCCUPIED] = t_now;
                    end else if (timed_out(PH_OCCUPIED, 64'(ANNOUNCE_WAIT))) begin
                        mark(PH_ANNOUNCE);
                    end
                end
                PH_CLOSED: begin
                    if (open_e) to_occupied();
                    if (!present && timed_out(PH_CLOSED, 64'(CLOSED_WAIT))) mark(PH_CHECK);
                end
                PH_CHECK: begin
                    if (open_e) to_occupied();
                    if (present) begin
                        to_occupied();
                    end else if (timed_out(PH_CHECK, 64'(CHECK_WAIT))) begin
                        light_s = 1'b0;
                        mark(PH_LEAVING);
                    end
                end
                PH_LEAVING: begin
                    if (open_e) to_occupied();
                    if (present) begin
                        to_occupied();
                    end else if (timed_out(PH_LEAVING, 64'(LEAVING_WAIT))) begin
                        to_idle();
                    end
                end
                PH_ANNOUNCE: begin
                    if (open_e) begin
                        to_occupied();
                    end else if (close_e) begin
                        mark(PH_CLOSED);
                    end
                    if (present) begin
                        to_occupied();
                    end else if (timed_out(PH_ANNOUNCE, 64'(ALARM_WAIT))) begin
                        fan_s = 1'b1;
                        music_s = 1'b0;
                        push_report(1'b0);
                        mark(PH_ALARM);
                    end
                end
                default: begin
                    if (open_e) begin
                        to_occupied();
                    end else if (close_e) begin
                        mark(PH_CLOSED);
                    end
                end
            endcase
        end
        r.phase = ph;
        r.light = light_s;
        r.fan = cfg_man_fan | fan_s;
        r.music = music_s;
        r.led = led_s;
        r.present = present;
        r.door_changed = changed;
        r.rep_n = rep_n;
        r.rep_first = rep_first;
        r.rep_second = rep_second;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            if (mismatches < 10) begin
                $display("Mismatch in %s of result %0d: expected %0h, got %0h",
                         name, results_seen, want, got);
            end
            mismatches++;
        end
    endfunction

    task automatic queue_sample(logic cmd, logic pir, logic reed, logic [31:0] now_s);
        t_sample s;
        s.command = cmd;
        s.pir = pir;
        s.reed = reed;
        s.now_s = now_s;
        samples_q.push_back(s);
    endtask

    task automatic wait_idle();
        while (samples_q.size() != 0 || in_valid || room_results_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    always @(posedge clk) begin : drive
        t_sample    s;
        t_reg_write w;
        if (!rst_n) begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && o_cfg_ready) apply_register(cfg_index, cfg_data);
            if (!cfg_valid || o_cfg_ready) begin
                if (reg_writes_q.size() != 0) begin
                    w = reg_writes_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.index;
                    cfg_data <= w.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
            if (in_valid && o_in_ready) begin
                s.command = in_command;
                s.pir = in_pir;
                s.reed = in_reed;
                s.now_s = in_now;
                room_results_due.push_back(advance_room(s));
            end
            if (!in_valid || o_in_ready) begin
                if (samples_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s = samples_q.pop_front();
                    in_valid <= 1'b1;
                    in_command <= s.command;
                    in_pir <= s.pir;
                    in_reed <= s.reed;
                    in_now <= s.now_s;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin : observe
        t_room_result want;
        if (rst_n && o_out_valid && out_ready) begin
            if (room_results_due.size() == 0) begin
                if (mismatches < 10) begin
                    $display("Unexpected result word: phase %0d", o_phase_code);
                end
                mismatches++;
            end else begin
                want = room_results_due.pop_front();
                check_field("phase_code", 32'(o_phase_code), 32'(want.phase));
                check_field("light_on", 32'(o_light_on), 32'(want.light));
                check_field("fan_on", 32'(o_fan_on), 32'(want.fan));
                check_field("music_on", 32'(o_music_on), 32'(want.music));
                check_field("led_on", 32'(o_led_on), 32'(want.led));
                check_field("person_present", 32'(o_person_present), 32'(want.present));
                check_field("door_level", 32'(o_door_level), 32'(want.door_level));
                check_field("door_changed", 32'(o_door_changed), 32'(want.door_changed));
                check_field("report_count", 32'(o_report_count), 32'(want.rep_n));
                check_field("report_first", 32'(o_report_first), 32'(want.rep_first));
                check_field("report_second", 32'(o_report_second), 32'(want.rep_second));
                phases_seen[want.phase] = 1'b1;
                if (want.rep_n > most_reports) most_reports = want.rep_n;
            end
            results_seen++;
        end
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped at cycle %0d with %0d results outstanding",
                 cycle_count, room_results_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : sequencer
        logic [15:0] w_detect;
        logic [15:0] w_hours;
        logic [15:0] w_fan;
        logic [15:0] w_music;
        int unsigned r;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk through every phase, both timer wraps and the force command.
        queue_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd0);
        queue_sample(CMD_FORCE,  1'b1, 1'b1, 32'd100);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd200);
        queue_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd201);
        queue_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd202);
        queue_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'd203);
        queue_sample(CMD_SAMPLE, 1'b1, 1'b0, 32'd204);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd210);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd220);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd230);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd231);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd500);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd530);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd531);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b1, 32'd532);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'hFFFF_FFFF);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'd2);
        queue_sample(CMD_FORCE,  1'b1, 1'b0, 32'd2);
        queue_sample(CMD_SAMPLE, 1'b0, 1'b0, 32'h8000_0000);
        queue_sample(CMD_SAMPLE, 1'b1, 1'b1, 32'h8000_0001);
        queue_sample(CMD_FORCE,  1'b0, 1'b0, 32'h5555_AAAA);
        wait_idle();

        for (int k = 0; k < SETTINGS_RUN; k++) begin
            w_fan = 16'($urandom()) & 16'hFFFE;
            w_music = 16'($urandom()) & 16'hFFFE;
            case (k)
                0: begin
                    w_detect = 16'd2;
                    w_hours = 16'd80;
                end
                1: begin
                    w_detect = 16'd0;
                    w_hours = 16'd0;
                    w_fan = w_fan | 16'd1;
                    w_music = w_music | 16'd1;
                end
                2: begin
                    w_detect = 16'hFFFF;
                    w_hours = 16'hFFFF;
                end
                3: begin
                    w_detect = {6'($urandom()), 10'd655};
                    w_hours = 16'd1;
                    w_fan = w_fan | 16'd1;
                end
                4: begin
                    w_detect = 16'd3;
                    w_hours = 16'($urandom());
                    w_music = w_music | 16'd1;
                end
                5: begin
                    w_detect = 16'd1;
                    w_hours = 16'd0;
                end
                6: begin
                    w_detect = 16'($urandom_range(5));
                    w_hours = 16'd2;
                    w_fan = w_fan | 16'($urandom_range(1));
                    w_music = w_music | 16'($urandom_range(1));
                end
                default: begin
                    w_detect = 16'd0;
                    w_hours = 16'd80;
                    w_music = w_music | 16'd1;
                end
            endcase
            reg_writes_q.push_back(t_reg_write'{CFG_DETECT_SAMPLES, w_detect});
            reg_writes_q.push_back(t_reg_write'{CFG_IDLE_FAN_HOURS, w_hours});
            reg_writes_q.push_back(t_reg_write'{CFG_MANUAL_FAN, w_fan});
            reg_writes_q.push_back(t_reg_write'{CFG_MANUAL_MUSIC, w_music});
            while (reg_writes_q.size() != 0 || cfg_valid) @(posedge clk);

            send_idle_pct <= (k % 4 == 1) ? 71 : (k % 4 == 3) ? 9 : 0;
            recv_stall_pct <= (k % 4 == 2) ? 71 : (k % 4 == 3) ? 9 : 0;
            if (k == 0) hold_arm <= 1'b1;

            // Mostly a plausible sensor history, with jumps in time and forced resets.
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                r = $urandom_range(99);
                if (r < 40) begin
                    gen_now = gen_now + $urandom_range(3);
                end else if (r < 75) begin
                    gen_now = gen_now + $urandom_range(30, 1);
                end else if (r < 90) begin
                    gen_now = gen_now + $urandom_range(400, 100);
                end else if (r < 95) begin
                    gen_now = gen_now + $urandom_range(100, 1) * HOUR_SECONDS;
                end else begin
                    gen_now = $urandom();
                end
                if ($urandom_range(99) < 20) gen_pir = ~gen_pir;
                if ($urandom_range(99) < 15) gen_reed = ~gen_reed;
                if ($urandom_range(99) < 3) begin
                    queue_sample(CMD_FORCE, 1'($urandom()), 1'($urandom()), gen_now);
                end else begin
                    queue_sample(CMD_SAMPLE, gen_pir, gen_reed, gen_now);
                end
            end
            wait_idle();
        end

        $display("Checked %0d result words over %0d register settings and four traffic patterns.",
                 results_seen, SETTINGS_RUN + 1);
        $display("Phases reached: %b, most music reports in one step: %0d",
                 phases_seen, most_reports);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== occupancy_light_fan_controller.f =====
+incdir+src
src/olfc_pkg.sv
src/occupancy_light_fan_controller.sv
sim/occupancy_light_fan_controller_tb.sv
